// ===== hdl/mm64_pkg.sv =====
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared constants and types for the streaming MurmurHash64A block: the
// mixing constant, the xor-shift amount and the multiplier handshake structs.
// ----------------------------------------------------------------------------
package mm64_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned HalfW  = 32;
	localparam int unsigned CountW = 4;
	localparam int unsigned LenW   = 31;
	localparam int unsigned SeedW  = 32;

	// Mixing multiplier and shift
	localparam logic [WordW-1:0] HashM = 64'hc6a4a7935bd1e995;
	localparam int unsigned      HashR = 47;

	// Request from the sequencer to the multiplier
	typedef struct packed {
		logic             start;
		logic [WordW-1:0] operand;
	} mul_req_t;

	// Response from the multiplier
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] product;
	} mul_rsp_t;

	// h ^ (h >> R)
	function automatic logic [WordW-1:0] xorshift(input logic [WordW-1:0] h);
		xorshift = h ^ (h >> HashR);
	endfunction

endpackage

// ===== hdl/mm64_if.sv =====
// ----------------------------------------------------------------------------
// mm64 channel interfaces
// Valid/ready channels for message words in and digests out.
// ----------------------------------------------------------------------------
interface mm64_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        first_word;
	logic        last_word;
	logic [30:0] message_length;

	modport source (
		output valid, data_word, byte_count, first_word, last_word, message_length,
		input  ready
	);
	modport sink (
		input  valid, data_word, byte_count, first_word, last_word, message_length,
		output ready
	);
endinterface

interface mm64_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest;

	modport source (
		output valid, digest,
		input  ready
	);
	modport sink (
		input  valid, digest,
		output ready
	);
endinterface

// ===== hdl/mm64_mul.sv =====
// ----------------------------------------------------------------------------
// mm64_mul
// Iterative multiply by the hash constant, modulo 2^64. One 32x32 multiplier
// is used in turn for lo*mlo and then the two cross terms into the top half.
// ----------------------------------------------------------------------------
module mm64_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  mm64_pkg::mul_req_t req,
	output mm64_pkg::mul_rsp_t rsp
);
	import mm64_pkg::*;

	logic [WordW-1:0] a_q;
	logic [WordW-1:0] acc_q;
	logic [1:0]       phase_q;
	logic             run_q;
	logic             done_q;

	logic [HalfW-1:0] a_half;
	logic [HalfW-1:0] m_half;
	logic [WordW-1:0] prod;

	// Operand half selection per phase
	always_comb begin
		a_half = (phase_q == 2'd1) ? a_q[WordW-1:HalfW] : a_q[HalfW-1:0];
		m_half = (phase_q == 2'd2) ? HashM[WordW-1:HalfW] : HashM[HalfW-1:0];
		prod   = WordW'(a_half) * WordW'(m_half);
	end

	// Phase control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q   <= 1'b1;
				phase_q <= 2'd0;
			end else if (run_q) begin
				if (phase_q == 2'd2) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// Operand latch and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end else if (run_q) begin
			if (phase_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q[WordW-1:HalfW] <= acc_q[WordW-1:HalfW] + prod[HalfW-1:0];
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

// ===== hdl/murmur64a_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur64a_stream_hash
// Streaming MurmurHash64A over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Usage:
//   msg  : sink channel, one word per transfer with byte count, first/last
//          marks and, on the first word, the message length.
//   hash : source channel, one digest per word marked last.
//   cfg_we/cfg_wdata : write of the signed 32-bit seed; write only while idle.
// Sequencing: every multiply by the hash constant runs on one shared unit
//   with a single 32x32 multiplier, in the steps issue, three partial
//   products and completion. A word takes one multiply if it is a first
//   word, then three if it is full or one if it is a tail word, and one
//   more if it is last; a last word then loads the output register from
//   its output state. msg.ready is low while a word is in work.
// Stall: the digest waits in its output register and the next word is still
//   taken; a following last word holds before its load until hash.ready.
// Reset: clears the sequencer, output valid, running hash and seed to zero.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	mm64_in_if.sink                  msg,
	mm64_out_if.source               hash,
	input  logic                     cfg_we,
	input  logic signed [31:0]       cfg_wdata
);
	import mm64_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LEN  = 3'd1;
	localparam logic [2:0] S_MIX1 = 3'd2;
	localparam logic [2:0] S_MIX2 = 3'd3;
	localparam logic [2:0] S_FOLD = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic             issued_q;
	logic [SeedW-1:0] seed_q;
	logic [WordW-1:0] h_q;
	logic [WordW-1:0] k_q;
	logic [LenW-1:0]  len_q;
	logic             full_q;
	logic             nz_q;
	logic             last_q;
	logic [WordW-1:0] fin_q;
	logic             out_valid_q;
	logic [WordW-1:0] digest_q;

	mul_req_t         mreq;
	mul_rsp_t         mrsp;
	logic             xfer;
	logic             full_in;
	logic             nz_in;
	logic [WordW-1:0] tail_word;
	logic [WordW-1:0] res_xs;

	// Next step after the seeding multiply, or straight after a transfer
	function automatic logic [2:0] route(input logic full, input logic nz, input logic last);
		if (full) begin
			route = S_MIX2 - 3'd1;
		end else if (nz) begin
			route = S_FOLD;
		end else if (last) begin
			route = S_FIN;
		end else begin
			route = S_IDLE;
		end
	endfunction

	assign xfer    = msg.valid && msg.ready;
	assign full_in = msg.byte_count[CountW-1];
	assign nz_in   = (msg.byte_count != '0);
	assign res_xs  = xorshift(mrsp.product);

	// Keep only the valid low bytes of a tail word
	always_comb begin
		tail_word = '0;
		for (int i = 0; i < 8; i++) begin
			if (msg.byte_count[2:0] > 3'(i)) begin
				tail_word[i*8 +: 8] = msg.data_word[i*8 +: 8];
			end
		end
	end

	// Multiplier request: issue once on entry to each multiply state
	always_comb begin
		mreq.start   = 1'b0;
		mreq.operand = k_q;
		if (!issued_q) begin
			case (state_q)
				S_LEN: begin
					mreq.start   = 1'b1;
					mreq.operand = {{(WordW-LenW){1'b0}}, len_q};
				end
				S_MIX1, S_MIX2: begin
					mreq.start   = 1'b1;
					mreq.operand = k_q;
				end
				S_FOLD: begin
					mreq.start   = 1'b1;
					mreq.operand = h_q ^ k_q;
				end
				S_FIN: begin
					mreq.start   = 1'b1;
					mreq.operand = xorshift(h_q);
				end
				default: begin
					mreq.start = 1'b0;
				end
			endcase
		end
	end

	mm64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// Sequencer and running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			h_q      <= '0;
			seed_q   <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (mreq.start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (xfer) begin
						state_q <= msg.first_word ? S_LEN
							: route(full_in, nz_in, msg.last_word);
					end
				end
				S_LEN: begin
					if (issued_q && mrsp.done) begin
						issued_q <= 1'b0;
						h_q      <= {{(WordW-SeedW){seed_q[SeedW-1]}}, seed_q} ^ mrsp.product;
						state_q  <= route(full_q, nz_q, last_q);
					end
				end
				S_MIX1: begin
					if (issued_q && mrsp.done) begin
						issued_q <= 1'b0;
						state_q  <= S_MIX2;
					end
				end
				S_MIX2: begin
					if (issued_q && mrsp.done) begin
						issued_q <= 1'b0;
						state_q  <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (issued_q && mrsp.done) begin
						issued_q <= 1'b0;
						h_q      <= mrsp.product;
						state_q  <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (issued_q && mrsp.done) begin
						issued_q <= 1'b0;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || hash.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload and mixed-word register
	always_ff @(posedge clk) begin
		if (xfer) begin
			k_q    <= full_in ? msg.data_word : tail_word;
			len_q  <= msg.message_length;
			full_q <= full_in;
			nz_q   <= nz_in;
			last_q <= msg.last_word;
		end else if (issued_q && mrsp.done) begin
			if (state_q == S_MIX1) begin
				k_q <= res_xs;
			end else if (state_q == S_MIX2) begin
				k_q <= mrsp.product;
			end else if (state_q == S_FIN) begin
				fin_q <= res_xs;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || hash.ready)) begin
			out_valid_q <= 1'b1;
		end else if (hash.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || hash.ready)) begin
			digest_q <= fin_q;
		end
	end

	assign msg.ready   = (state_q == S_IDLE);
	assign hash.valid  = out_valid_q;
	assign hash.digest = digest_q;

endmodule

// ===== hdl/mm64_checker.sv =====
// ----------------------------------------------------------------------------
// mm64_checker
// Port-level checks for the streaming hash block, bound to the top level.
// ----------------------------------------------------------------------------
module mm64_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] out_digest
);

	// A new digest is only loaded while the sequencer is busy
	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("digest appeared without a word in work");

	// Stalled digest stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("digest dropped while stalled");

	// Stalled digest keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_digest))
		else $error("digest changed while stalled");

endmodule

bind murmur64a_stream_hash mm64_checker u_mm64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (msg.valid),
	.in_ready   (msg.ready),
	.out_valid  (hash.valid),
	.out_ready  (hash.ready),
	.out_digest (hash.digest)
);
